// ===== sv/tnm_pkg.sv =====
// ============================================================================
// tnm_pkg: shared types and constants for the throttle notch momentum core
// Holds the transaction payload structs, the register index codes, the
// default parameter values and the quadrature step tables.
// ============================================================================
`timescale 1ns / 1ps

package tnm_pkg;

    // Default values for the parameters of the top level.
    localparam int POLL_PERIOD_DEF = 8;
    localparam int MAX_NOTCH_DEF   = 8;
    localparam int SAMPLE_BITS_DEF = 12;

    // Fixed field widths of the transaction payloads.
    localparam int BRAKE_FIELD_W = 12;
    localparam int NOTCH_W       = 4;
    localparam int SPEED_W       = 8;
    localparam int FACTOR_W      = 8;
    localparam int CFG_INDEX_W   = 8;
    localparam int PHASE_W       = 2;

    // Register reset values.
    localparam logic [FACTOR_W-1:0] DRAG_RESET      = 8'd1;
    localparam logic [FACTOR_W-1:0] ACCEL_RESET     = 8'd1;
    localparam logic [FACTOR_W-1:0] BRAKE_GAIN_RESET = 8'd1;
    localparam logic [SPEED_W-1:0]  MAX_SPEED_RESET = 8'd255;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DRAG_FACTOR  = 8'd0,
        REG_ACCEL_FACTOR = 8'd1,
        REG_BRAKE_GAIN   = 8'd2,
        REG_MAX_SPEED    = 8'd3
    } cfg_reg_t;

    typedef struct packed {
        logic                     pin_a;
        logic                     pin_b;
        logic [BRAKE_FIELD_W-1:0] brake_sample;
        logic                     train_selected;
        logic                     reverser_neutral;
    } in_item_t;

    typedef struct packed {
        logic [NOTCH_W-1:0] notch;
        logic [SPEED_W-1:0] speed;
        logic               throttle_changed;
        logic               brake_changed;
        logic               speed_updated;
        logic               stopped_idle;
    } out_item_t;

    // Phase that counts as a step down from the given phase.
    function automatic logic [PHASE_W-1:0] step_lower(input logic [PHASE_W-1:0] ph);
        logic [PHASE_W-1:0] r;
        case (ph)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd3;
            2'd2:    r = 2'd0;
            2'd3:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    // Phase that counts as a step up from the given phase.
    function automatic logic [PHASE_W-1:0] step_raise(input logic [PHASE_W-1:0] ph);
        logic [PHASE_W-1:0] r;
        case (ph)
            2'd0:    r = 2'd2;
            2'd1:    r = 2'd0;
            2'd2:    r = 2'd3;
            2'd3:    r = 2'd1;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/throttle_notch_momentum_core.sv =====
// ============================================================================
// throttle_notch_momentum_core: quadrature throttle notch with momentum speed
// Each input transaction is one poll tick and yields exactly one result
// transaction. The core takes one transaction per clock cycle while its
// results are taken; a tick is held in the input register and then passes
// through the notch, multiply and clamp logic into the result register,
// which is where the rate is set. A result that waits for the
// consumer does not stop the next transaction from entering the input
// register; only when both registers are full and the result is not taken
// does in_ready fall. The notch follows Gray-code steps of the two pins and
// saturates at 0 and MAX_NOTCH; an illegal two-bit jump returns it to zero.
// On every POLL_PERIOD-th tick (the first one being the tick after
// POLL_PERIOD ticks have passed since reset), with a train selected and the
// reverser out of neutral, the speed gains notch * accel_factor and loses the
// sum of drag_factor and brake_gain * brake_sample, clamped to 0..max_speed.
// Configuration registers are written through the cfg channel, which is
// always ready; writes should only be made while no transaction is in flight.
// ============================================================================
`timescale 1ns / 1ps

module throttle_notch_momentum_core
    import tnm_pkg::*;
#(
    parameter int POLL_PERIOD = POLL_PERIOD_DEF,
    parameter int MAX_NOTCH   = MAX_NOTCH_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_item_t              out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [FACTOR_W-1:0]    cfg_data
);

    // The brake sample is limited both by the field width and by SAMPLE_BITS.
    localparam int BRAKE_W = (SAMPLE_BITS < BRAKE_FIELD_W) ? SAMPLE_BITS : BRAKE_FIELD_W;
    localparam int TICK_W  = $clog2(POLL_PERIOD + 1);
    localparam int PROD_A_W = NOTCH_W + FACTOR_W;
    localparam int POS_W    = PROD_A_W + 1;
    localparam int PROD_B_W = FACTOR_W + BRAKE_W;
    localparam int NEG_W    = PROD_B_W + 1;
    localparam int CMP_W    = (POS_W > NEG_W) ? POS_W : NEG_W;

    // Configuration registers.
    logic [FACTOR_W-1:0] drag_reg;
    logic [FACTOR_W-1:0] accel_reg;
    logic [FACTOR_W-1:0] brake_gain_reg;
    logic [SPEED_W-1:0]  max_speed_reg;

    // Block state.
    logic [PHASE_W-1:0] phase_reg;
    logic [NOTCH_W-1:0] notch_reg;
    logic [TICK_W-1:0]  tick_reg;
    logic [SPEED_W-1:0] speed_reg;
    logic [BRAKE_W-1:0] last_brake_reg;

    // Input register and result register, each with its valid flag.
    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;

    logic advance;

    logic [PHASE_W-1:0] phase_next;
    logic [NOTCH_W-1:0] notch_next;
    logic [TICK_W-1:0]  tick_next;
    logic [SPEED_W-1:0] speed_next;
    logic [BRAKE_W-1:0] sample;
    logic               due;
    logic               apply;
    logic [PROD_A_W-1:0] prod_a;
    logic [PROD_B_W-1:0] prod_b;
    logic [CMP_W-1:0]    pos_sum;
    logic [CMP_W-1:0]    neg_sum;
    logic [CMP_W-1:0]    diff;
    out_item_t           out_item_next;

    // ------------------------------------------------------------------------
    // Handshake. The tick held in the input register moves into the result
    // register whenever the result register is empty or its transaction is
    // being taken in this cycle; the input register then frees up at once.
    // ------------------------------------------------------------------------
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------------
    // Tick logic, working on the transaction in the input register.
    // ------------------------------------------------------------------------
    always_comb
    begin
        phase_next = {in_item_reg.pin_b, in_item_reg.pin_a};
        sample     = in_item_reg.brake_sample[BRAKE_W-1:0];

        // Notch movement from the quadrature phase.
        notch_next = notch_reg;
        if (phase_next != phase_reg)
        begin
            if (phase_next == step_lower(phase_reg))
            begin
                if (notch_reg != '0)
                begin
                    notch_next = notch_reg - NOTCH_W'(1);
                end
            end
            else if (phase_next == step_raise(phase_reg))
            begin
                if (notch_reg < NOTCH_W'(MAX_NOTCH))
                begin
                    notch_next = notch_reg + NOTCH_W'(1);
                end
            end
            else
            begin
                // Both pins changed at once: the position is lost.
                notch_next = '0;
            end
        end

        // Update period counter.
        due       = (tick_reg == TICK_W'(POLL_PERIOD));
        tick_next = due ? TICK_W'(1) : tick_reg + TICK_W'(1);
        apply     = due && in_item_reg.train_selected && !in_item_reg.reverser_neutral;

        // Momentum: gain from the notch against drag and brake loss.
        prod_a  = PROD_A_W'(notch_next) * PROD_A_W'(accel_reg);
        prod_b  = PROD_B_W'(brake_gain_reg) * PROD_B_W'(sample);
        pos_sum = CMP_W'(speed_reg) + CMP_W'(prod_a);
        neg_sum = CMP_W'(drag_reg) + CMP_W'(prod_b);
        diff    = pos_sum - neg_sum;

        speed_next = speed_reg;
        if (apply)
        begin
            if (neg_sum >= pos_sum)
            begin
                speed_next = '0;
            end
            else if (diff > CMP_W'(max_speed_reg))
            begin
                speed_next = max_speed_reg;
            end
            else
            begin
                speed_next = diff[SPEED_W-1:0];
            end
        end

        out_item_next.notch            = notch_next;
        out_item_next.speed            = speed_next;
        out_item_next.throttle_changed = (phase_next != phase_reg);
        out_item_next.brake_changed    = (sample != last_brake_reg);
        out_item_next.speed_updated    = apply;
        out_item_next.stopped_idle     = apply && (speed_next == '0) && (notch_next == '0);
    end

    // ------------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drag_reg       <= DRAG_RESET;
            accel_reg      <= ACCEL_RESET;
            brake_gain_reg <= BRAKE_GAIN_RESET;
            max_speed_reg  <= MAX_SPEED_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DRAG_FACTOR:  drag_reg       <= cfg_data;
                REG_ACCEL_FACTOR: accel_reg      <= cfg_data;
                REG_BRAKE_GAIN:   brake_gain_reg <= cfg_data;
                REG_MAX_SPEED:    max_speed_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Control state and block state.
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            phase_reg      <= '0;
            notch_reg      <= '0;
            tick_reg       <= '0;
            speed_reg      <= '0;
            last_brake_reg <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg  <= 1'b1;
                phase_reg      <= phase_next;
                notch_reg      <= notch_next;
                tick_reg       <= tick_next;
                speed_reg      <= speed_next;
                last_brake_reg <= sample;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_data;
        end
        if (advance)
        begin
            out_item_reg <= out_item_next;
        end
    end

`ifndef SYNTH
    // The notch never leaves its range.
    a_notch_range: assert property (@(posedge clk) disable iff (!rst_n)
        notch_reg <= NOTCH_W'(MAX_NOTCH))
        else $error("notch beyond MAX_NOTCH");

    // The period counter never passes the period.
    a_tick_range: assert property (@(posedge clk) disable iff (!rst_n)
        tick_reg <= TICK_W'(POLL_PERIOD))
        else $error("tick counter beyond POLL_PERIOD");

    // A stopped flag only comes with an applied update at zero speed and notch.
    a_idle_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.stopped_idle) |->
            (out_data.speed_updated && out_data.speed == '0 && out_data.notch == '0))
        else $error("stopped_idle without an idle update");

    // A held input transaction is not overwritten while the result stalls.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("input register overrun while result stalled");

    // A tick leaving the input register always lands in the result register.
    a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid)
        else $error("advanced transaction lost");
`endif

endmodule

// ===== dv/tb_throttle_notch_momentum_core.sv =====
// ============================================================================
// tb_throttle_notch_momentum_core: self-checking bench for the notch core
// A short directed walk through Gray-code steps, notch saturation, an illegal
// jump and the first speed updates is followed by random tick traffic under
// several register settings. An in-bench model of the notch and speed logic
// predicts every result transaction, and each one is compared field by field.
// ============================================================================
`timescale 1ns / 1ps

module tb_throttle_notch_momentum_core;

    import tnm_pkg::*;

    // ------------------------------------------------------------------------
    // Bench constants
    // ------------------------------------------------------------------------
    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 7;
    localparam int DIR_ROWS       = 25;
    localparam int RAND_PER_PHASE = 235;
    // Settle time before a register write; it covers the input and result
    // registers of the core with room to spare.
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 16;
    // Slowest correct run is roughly 1900 items plus the drains between
    // settings; the limit is several times as long.
    localparam int CYCLE_LIMIT    = 500_000;

    // An index that maps to no register; a write to it must change nothing.
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 8'hA5;

    // ------------------------------------------------------------------------
    // Clock, reset and the ports of the core
    // ------------------------------------------------------------------------
    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    in_item_t               in_data;
    logic                   out_valid;
    logic                   out_ready;
    out_item_t              out_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [FACTOR_W-1:0]    cfg_data;

    throttle_notch_momentum_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------------
    // Notch and speed model
    // The model keeps its own copy of the core state and registers. It is
    // advanced at every accepted input transaction and every accepted
    // register write, exactly as the core sees them.
    // ------------------------------------------------------------------------
    logic [PHASE_W-1:0]       mdl_phase;
    logic [NOTCH_W-1:0]       mdl_notch;
    logic [7:0]               mdl_ticks;
    logic [SPEED_W-1:0]       mdl_speed;
    logic [BRAKE_FIELD_W-1:0] mdl_brake;
    logic [FACTOR_W-1:0]      mdl_drag;
    logic [FACTOR_W-1:0]      mdl_accel;
    logic [FACTOR_W-1:0]      mdl_gain;
    logic [SPEED_W-1:0]       mdl_max_speed;

    // Quadrature phase one step down and one step up from a given phase. The
    // phase is pin_b:pin_a, so the sequence 0, 2, 3, 1 counts upwards.
    function automatic logic [PHASE_W-1:0] phase_down(input logic [PHASE_W-1:0] ph);
        logic [PHASE_W-1:0] r;
        case (ph)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd3;
            2'd2:    r = 2'd0;
            default: r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [PHASE_W-1:0] phase_up(input logic [PHASE_W-1:0] ph);
        logic [PHASE_W-1:0] r;
        case (ph)
            2'd0:    r = 2'd2;
            2'd1:    r = 2'd0;
            2'd2:    r = 2'd3;
            default: r = 2'd1;
        endcase
        return r;
    endfunction

    task automatic model_reset();
        mdl_phase     = '0;
        mdl_notch     = '0;
        mdl_ticks     = '0;
        mdl_speed     = '0;
        mdl_brake     = '0;
        mdl_drag      = 8'd1;
        mdl_accel     = 8'd1;
        mdl_gain      = 8'd1;
        mdl_max_speed = 8'd255;
    endtask

    // Works out the result of one poll tick and advances the model state.
    function automatic out_item_t predict_tick(input in_item_t it);
        logic [PHASE_W-1:0] nph;
        int                 s;
        out_item_t          r;
        nph = {it.pin_b, it.pin_a};
        r   = '0;
        if (nph != mdl_phase) begin
            r.throttle_changed = 1'b1;
            if (nph == phase_down(mdl_phase)) begin
                if (mdl_notch != 0)
                    mdl_notch = mdl_notch - NOTCH_W'(1);
            end
            else if (nph == phase_up(mdl_phase)) begin
                if (mdl_notch < MAX_NOTCH_DEF)
                    mdl_notch = mdl_notch + NOTCH_W'(1);
            end
            else begin
                // Both pins moved at once: the notch falls back to idle.
                mdl_notch = '0;
            end
        end
        mdl_phase = nph;

        if (it.brake_sample != mdl_brake) begin
            r.brake_changed = 1'b1;
            mdl_brake       = it.brake_sample;
        end

        // The speed moves only on a due tick, and then only with a train
        // selected and the reverser out of neutral. The brake used is the
        // sample of this very tick.
        if (mdl_ticks == POLL_PERIOD_DEF) begin
            if (it.train_selected && !it.reverser_neutral) begin
                s = int'(mdl_speed) + int'(mdl_notch) * int'(mdl_accel)
                    - int'(mdl_drag) - int'(mdl_gain) * int'(mdl_brake);
                if (s < 0)
                    s = 0;
                if (s > int'(mdl_max_speed))
                    s = int'(mdl_max_speed);
                mdl_speed        = s[SPEED_W-1:0];
                r.speed_updated  = 1'b1;
                r.stopped_idle   = (mdl_speed == 0) && (mdl_notch == 0);
            end
            mdl_ticks = '0;
        end
        mdl_ticks = mdl_ticks + 8'd1;

        r.notch = mdl_notch;
        r.speed = mdl_speed;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    out_item_t pending_results[$];
    int        mismatches;
    int        cycle_count;

    // Where the directed table gives a result by hand, the sender raises
    // this flag alongside the payload and the typed value is expected in
    // place of the predicted one.
    logic      pinned_valid;
    out_item_t pinned_result;

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result(input out_item_t want, input out_item_t got);
        compare_field("notch", int'(want.notch), int'(got.notch));
        compare_field("speed", int'(want.speed), int'(got.speed));
        compare_field("throttle_changed", int'(want.throttle_changed),
                      int'(got.throttle_changed));
        compare_field("brake_changed", int'(want.brake_changed),
                      int'(got.brake_changed));
        compare_field("speed_updated", int'(want.speed_updated),
                      int'(got.speed_updated));
        compare_field("stopped_idle", int'(want.stopped_idle),
                      int'(got.stopped_idle));
    endtask

    // Everything is sampled at the rising edge, while the inputs only move at
    // the falling edge, so no sample depends on the order of events.
    always @(posedge clk) begin : monitor
        out_item_t predicted;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t ns: result transaction with nothing expected, actual %h",
                             $time, out_data);
                    mismatches++;
                end
                else begin
                    check_result(pending_results.pop_front(), out_data);
                end
            end
            if (in_valid && in_ready) begin
                predicted = predict_tick(in_data);
                if (pinned_valid)
                    pending_results.push_back(pinned_result);
                else
                    pending_results.push_back(predicted);
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_DRAG_FACTOR:  mdl_drag      = cfg_data;
                    REG_ACCEL_FACTOR: mdl_accel     = cfg_data;
                    REG_BRAKE_GAIN:   mdl_gain      = cfg_data;
                    REG_MAX_SPEED:    mdl_max_speed = cfg_data;
                    default:          ;
                endcase
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Watchdog expired after %0d cycles", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Directed table
    // Rows with chk set carry a result that is plain from the logic (reset
    // state, first step up, an illegal jump, the full-scale brake, the first
    // update that leaves the train stopped). The rest are left to the model.
    // ------------------------------------------------------------------------
    typedef struct {
        bit        pa;
        bit        pb;
        bit [11:0] brake;
        bit        sel;
        bit        neu;
        bit        chk;
        bit [3:0]  notch;
        bit [7:0]  speed;
        bit        thr;
        bit        brk;
        bit        upd;
        bit        idle;
    } dir_row_t;

    dir_row_t dir_table [DIR_ROWS] = '{
        // pa pb brake     sel neu chk notch speed   thr brk upd idle
        '{0, 0, 12'd0,    1, 0,  1, 4'd0, 8'd0,   0, 0, 0, 0},  // reset state
        '{0, 1, 12'd0,    1, 0,  1, 4'd1, 8'd0,   1, 0, 0, 0},  // first step up
        '{1, 1, 12'd0,    1, 0,  0, 4'd0, 8'd0,   0, 0, 0, 0},
        '{1, 0, 12'd0,    1, 0,  0, 4'd0, 8'd0,   0, 0, 0, 0},
        '{0, 0, 12'd0,    1, 0,  0, 4'd0, 8'd0,   0, 0, 0, 0},
        '{1, 0, 12'd0,    1, 0,  0, 4'd0, 8'd0,   0, 0, 0, 0},  // step down
        '{0, 1, 12'd0,    1, 0,  1, 4'd0, 8'd0,   1, 0, 0, 0},  // illegal jump
        '{0, 1, 12'd4095, 1, 0,  1, 4'd0, 8'd0,   0, 1, 0, 0},  // full brake
        '{0, 1, 12'd4095, 1, 0,  1, 4'd0, 8'd0,   0, 0, 1, 1},  // first update
        '{1, 1, 12'd0,    1, 0,  0, 4'd0, 8'd0,   0, 0, 0, 0},  // climb to top
        '{1, 0, 12'd0,    1, 0,  0, 4'd0, 8'd0,   0, 0, 0, 0},
        '{0, 0, 12'd0,    1, 0,  0, 4'd0, 8'd0,   0, 0, 0, 0},
        '{0, 1, 12'd0,    1, 0,  0, 4'd0, 8'd0,   0, 0, 0, 0},
        '{1, 1, 12'd0,    1, 0,  0, 4'd0, 8'd0,   0, 0, 0, 0},
        '{1, 0, 12'd0,    1, 0,  0, 4'd0, 8'd0,   0, 0, 0, 0},
        '{0, 0, 12'd0,    1, 0,  0, 4'd0, 8'd0,   0, 0, 0, 0},
        '{0, 1, 12'd0,    1, 0,  0, 4'd0, 8'd0,   0, 0, 0, 0},  // top notch, update
        '{1, 1, 12'd0,    1, 0,  0, 4'd0, 8'd0,   0, 0, 0, 0},  // held at the top
        '{1, 0, 12'd0,    1, 0,  0, 4'd0, 8'd0,   0, 0, 0, 0},
        '{1, 1, 12'd0,    1, 0,  0, 4'd0, 8'd0,   0, 0, 0, 0},  // walk back down
        '{0, 1, 12'd0,    1, 0,  0, 4'd0, 8'd0,   0, 0, 0, 0},
        '{0, 0, 12'd0,    1, 0,  0, 4'd0, 8'd0,   0, 0, 0, 0},
        '{1, 0, 12'd0,    1, 0,  0, 4'd0, 8'd0,   0, 0, 0, 0},
        '{1, 1, 12'd0,    1, 0,  0, 4'd0, 8'd0,   0, 0, 0, 0},
        '{1, 1, 12'd0,    1, 1,  0, 4'd0, 8'd0,   0, 0, 0, 0}   // due, but neutral
    };

    // ------------------------------------------------------------------------
    // Sender
    // Every task below is entered and left at a falling edge. After an
    // accepted transaction in_valid is left high, so that a following
    // transaction with no gap never sees valid lowered and raised in the
    // same time step.
    // ------------------------------------------------------------------------
    logic [PHASE_W-1:0]       sent_phase;
    logic [BRAKE_FIELD_W-1:0] sent_brake;

    task automatic send_tick(input in_item_t it, input logic chk,
                             input out_item_t typed, input int gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      <= 1'b1;
        in_data       <= it;
        pinned_valid  <= chk;
        pinned_result <= typed;
        sent_phase     = {it.pin_b, it.pin_a};
        sent_brake     = it.brake_sample;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stops sending and waits until every expected result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // Leaves cfg_valid high on return, in the same way as send_tick.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [FACTOR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Registers are only rewritten with the core empty: every result in, and
    // its two pipeline stages given time to settle.
    task automatic reprogram(input logic [FACTOR_W-1:0] drag,
                             input logic [FACTOR_W-1:0] accel,
                             input logic [FACTOR_W-1:0] gain,
                             input logic [SPEED_W-1:0] top);
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        write_reg(REG_DRAG_FACTOR, drag);
        write_reg(REG_ACCEL_FACTOR, accel);
        write_reg(REG_BRAKE_GAIN, gain);
        write_reg(REG_MAX_SPEED, top);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_directed();
        int       i;
        dir_row_t row;
        in_item_t it;
        out_item_t typed;
        for (i = 0; i < DIR_ROWS; i++) begin
            row                 = dir_table[i];
            it.pin_a            = row.pa;
            it.pin_b            = row.pb;
            it.brake_sample     = row.brake;
            it.train_selected   = row.sel;
            it.reverser_neutral = row.neu;
            typed.notch            = row.notch;
            typed.speed            = row.speed;
            typed.throttle_changed = row.thr;
            typed.brake_changed    = row.brk;
            typed.speed_updated    = row.upd;
            typed.stopped_idle     = row.idle;
            send_tick(it, row.chk, typed, $urandom_range(0, 15));
        end
    endtask

    // Random ticks. Most ticks are legal Gray-code steps, with the bias
    // between raising and lowering redrawn now and then so that the notch
    // reaches both ends; a few are held phases or illegal jumps. The brake
    // mostly stays put or sits low, so that the speed has room to build up.
    task automatic run_random(input int count);
        int                 i;
        int                 r;
        int                 burst_left;
        int                 raise_pct;
        bit                 calm;
        logic [PHASE_W-1:0] ph;
        in_item_t           it;
        burst_left = 0;
        raise_pct  = 50;
        calm       = 1'b0;
        for (i = 0; i < count; i++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(8, 40);
                calm       = ($urandom_range(0, 3) == 0);
                r          = $urandom_range(0, 2);
                raise_pct  = (r == 0) ? 20 : (r == 1) ? 50 : 85;
            end
            burst_left--;

            // Now and again hold back until the core has emptied.
            if ($urandom_range(0, 149) == 0)
                drain_results();

            r = $urandom_range(0, 99);
            if (r < 6)
                ph = sent_phase ^ 2'b11;
            else if (r < 16)
                ph = sent_phase;
            else if ($urandom_range(0, 99) < raise_pct)
                ph = phase_up(sent_phase);
            else
                ph = phase_down(sent_phase);
            it.pin_a = ph[0];
            it.pin_b = ph[1];

            r = $urandom_range(0, 99);
            if (r < 40)
                it.brake_sample = sent_brake;
            else if (r < 60)
                it.brake_sample = '0;
            else if (r < 82)
                it.brake_sample = BRAKE_FIELD_W'($urandom_range(1, 7));
            else if (r < 94)
                it.brake_sample = BRAKE_FIELD_W'($urandom_range(0, 4095));
            else
                it.brake_sample = 12'd4095;

            it.train_selected   = ($urandom_range(0, 9) != 0);
            it.reverser_neutral = ($urandom_range(0, 9) == 0);

            send_tick(it, 1'b0, '0, calm ? 0 : $urandom_range(0, 15));
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver
    // Before each result it holds out_ready low for a drawn number of cycles,
    // with calm stretches in which it takes every result at once.
    // ------------------------------------------------------------------------
    initial begin : receiver
        int stall;
        int burst_left;
        bit calm;
        burst_left = 0;
        calm       = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(8, 40);
                calm       = ($urandom_range(0, 3) == 0);
            end
            burst_left--;
            stall = calm ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        out_ready     = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        pinned_valid  = 1'b0;
        pinned_result = '0;
        mismatches    = 0;
        cycle_count   = 0;
        sent_phase    = '0;
        sent_brake    = '0;
        model_reset();

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Register reset values first: directed walk, then random ticks.
        run_directed();
        run_random(RAND_PER_PHASE);

        // No drag and no brake effect, full acceleration: the speed runs up
        // to the top of the range.
        reprogram(8'd0, 8'd255, 8'd0, 8'd255);
        run_random(RAND_PER_PHASE);

        // Ceiling lowered under a running train with nothing to slow it: the
        // high speed stands until the next update clamps it.
        reprogram(8'd0, 8'd0, 8'd0, 8'd40);
        run_random(RAND_PER_PHASE);

        // Every register at full scale; a write to an unmapped index must
        // leave them all alone.
        reprogram(8'd255, 8'd255, 8'd255, 8'd255);
        write_reg(REG_UNMAPPED, 8'd0);
        cfg_valid <= 1'b0;
        run_random(RAND_PER_PHASE);

        // A ceiling of zero pins the speed at zero.
        reprogram(8'd1, 8'd1, 8'd1, 8'd0);
        run_random(RAND_PER_PHASE);

        // Two settings of ordinary driving.
        reprogram(8'd2, 8'd30, 8'd1, 8'd200);
        run_random(RAND_PER_PHASE);
        reprogram(8'd5, 8'd12, 8'd3, 8'd100);
        run_random(RAND_PER_PHASE);

        // One drawn at random over the full width of each register.
        reprogram(FACTOR_W'($urandom_range(0, 255)), FACTOR_W'($urandom_range(0, 255)),
                  FACTOR_W'($urandom_range(0, 255)), SPEED_W'($urandom_range(0, 255)));
        run_random(RAND_PER_PHASE);

        // Wait for the last results, then allow a few more cycles so that a
        // stray extra result would still be caught.
        drain_results();
        repeat (TAIL_CYCLES) @(negedge clk);

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/tnm_pkg.sv
sv/throttle_notch_momentum_core.sv
dv/tb_throttle_notch_momentum_core.sv
